@@ sv/lgre_pkg.sv @@
// Shared types and constants for the Game of Life row engine.
// No dependencies; every other file of the block except lgre_fifo refers to this package.
package lgre_pkg;

   // Port widths fixed by the row format
   localparam int ROW_W   = 64;
   localparam int WIDTH_W = 7;

   // Rule B3/S23 neighbor counts
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // Reset value of the column-width register
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd64;

   // Control part of a queued job
   typedef struct packed {
      logic held;   // a middle row was pending when the request arrived
      logic last;   // request closed the frame
   } lgre_job_ctl_type;

endpackage

@@ sv/lgre_if.sv @@
// Valid/ready channel interfaces of the Game of Life row engine.
// Depends on lgre_pkg for the payload widths.

// Row request channel
interface lgre_req_if;
   logic                       valid;
   logic                       ready;
   logic [lgre_pkg::ROW_W-1:0] row_bits;
   logic                       last_row;

   modport source (output valid, output row_bits, output last_row, input ready);
   modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

// Result row channel
interface lgre_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lgre_pkg::ROW_W-1:0] next_row;
   logic                       last_of_frame;

   modport source (output valid, output next_row, output last_of_frame, input ready);
   modport sink   (input valid, input next_row, input last_of_frame, output ready);
endinterface

// Column-width register write channel
interface lgre_csr_if;
   logic                         valid;
   logic                         ready;
   logic [lgre_pkg::WIDTH_W-1:0] width_in_use;

   modport source (output valid, output width_in_use, input ready);
   modport sink   (input valid, input width_in_use, output ready);
endinterface

@@ sv/lgre_front.sv @@
// Front end: width register, row masking and the two-row line buffer.
// Depends on lgre_pkg and lgre_if; pushes one job per request that has results.
module lgre_front #(
   parameter int COLS  = 64,
   parameter int JOB_W = 4 * COLS + 2
) (
   input  logic              clock,
   input  logic              reset,
   lgre_req_if.sink          req,
   lgre_csr_if.sink          csr,
   output logic              job_valid,
   input  logic              job_ready,
   output logic [JOB_W-1:0]  job_data
);

   logic [lgre_pkg::WIDTH_W-1:0] width_ff;
   logic [COLS-1:0]              row_above_ff, row_above_in;
   logic [COLS-1:0]              row_middle_ff, row_middle_in;
   logic                         held_ff, held_in;
   logic [COLS-1:0]              mask;
   logic [COLS-1:0]              cur;
   logic                         accept;
   lgre_pkg::lgre_job_ctl_type   ctl;

   // Width register; writes taken at any time
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= lgre_pkg::WIDTH_RESET;
      end else if (csr.valid) begin
         width_ff <= csr.width_in_use;
      end
   end

   // Column mask: column c is live when width exceeds c
   for (genvar c = 0; c < COLS; c++) begin : g_mask
      assign mask[c] = (width_ff > lgre_pkg::WIDTH_W'(c));
   end

   assign cur    = req.row_bits[COLS-1:0] & mask;
   assign accept = req.valid && req.ready;

   // Stall only when the queue is full
   assign req.ready = job_ready;

   // Requests with no pending row and no frame end produce no job
   assign ctl.held  = held_ff;
   assign ctl.last  = req.last_row;
   assign job_valid = req.valid && (held_ff || req.last_row);
   assign job_data  = {ctl, mask, row_above_ff, row_middle_ff, cur};

   // Line buffer update; held rows are zero whenever nothing is held
   always_comb begin
      row_above_in  = row_above_ff;
      row_middle_in = row_middle_ff;
      held_in       = held_ff;
      if (accept) begin
         if (req.last_row) begin
            row_above_in  = '0;
            row_middle_in = '0;
            held_in       = 1'b0;
         end else begin
            row_above_in  = row_middle_ff;
            row_middle_in = cur;
            held_in       = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_above_ff  <= '0;
         row_middle_ff <= '0;
         held_ff       <= 1'b0;
      end else begin
         row_above_ff  <= row_above_in;
         row_middle_ff <= row_middle_in;
         held_ff       <= held_in;
      end
   end

endmodule

@@ sv/lgre_fifo.sv @@
// Small register queue that decouples the front end from the back end.
// No package dependency; DEPTH must be a power of two.
module lgre_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/lgre_back.sv @@
// Back end: 64 cell lanes apply B3/S23 to a queued job, one result row per cycle while rsp is not stalled.
// Depends on lgre_pkg and lgre_if; a job expands to one or two result rows.
module lgre_back #(
   parameter int COLS  = 64,
   parameter int JOB_W = 4 * COLS + 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  logic [JOB_W-1:0]  job_data,
   lgre_rsp_if.source        rsp
);

   localparam int CTL_W = $bits(lgre_pkg::lgre_job_ctl_type);

   // Phase codes of a job with two result rows
   localparam logic PH_FIRST  = 1'b0;
   localparam logic PH_SECOND = 1'b1;

   lgre_pkg::lgre_job_ctl_type ctl;
   logic [COLS-1:0]  mask, up, mid, down;
   logic [COLS-1:0]  sel_up, sel_mid, sel_down;
   logic [COLS+1:0]  up_x, mid_x, down_x;
   logic [COLS-1:0]  lane_res;
   logic             phase_ff, phase_in;
   logic             out_valid_ff, out_valid_in;
   logic [COLS-1:0]  next_row_ff, next_row_in;
   logic             lof_ff, lof_in;
   logic             do_center;
   logic             load;
   logic             fire;
   logic             done_job;

   // Unpack job
   assign ctl  = lgre_pkg::lgre_job_ctl_type'(job_data[JOB_W-1 -: CTL_W]);
   assign mask = job_data[4*COLS-1:3*COLS];
   assign up   = job_data[3*COLS-1:2*COLS];
   assign mid  = job_data[2*COLS-1:COLS];
   assign down = job_data[COLS-1:0];

   // Held row first, then the bottom row when the frame ends
   assign do_center = (phase_ff == PH_FIRST) && ctl.held;
   assign done_job  = !(do_center && ctl.last);

   always_comb begin
      if (do_center) begin
         sel_up   = up & mask;
         sel_mid  = mid & mask;
         sel_down = down;
      end else begin
         sel_up   = mid & mask;
         sel_mid  = down;
         sel_down = '0;
      end
   end

   // Dead border on both sides
   assign up_x   = {1'b0, sel_up,   1'b0};
   assign mid_x  = {1'b0, sel_mid,  1'b0};
   assign down_x = {1'b0, sel_down, 1'b0};

   // One lane per column
   for (genvar c = 0; c < COLS; c++) begin : g_lane
      logic [3:0] n;
      assign n = 4'(up_x[c]) + 4'(up_x[c+1]) + 4'(up_x[c+2])
               + 4'(mid_x[c]) + 4'(mid_x[c+2])
               + 4'(down_x[c]) + 4'(down_x[c+1]) + 4'(down_x[c+2]);
      assign lane_res[c] = (n == lgre_pkg::BIRTH_COUNT)
                        || ((n == lgre_pkg::SURVIVE_COUNT) && mid_x[c+1]);
   end

   // Output register loads when empty or being drained
   assign load      = !out_valid_ff || rsp.ready;
   assign fire      = job_valid && load;
   assign job_ready = load && done_job;

   always_comb begin
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff;
      next_row_in  = next_row_ff;
      lof_in       = lof_ff;
      if (load) begin
         out_valid_in = job_valid;
      end
      if (fire) begin
         next_row_in = lane_res & mask;
         lof_in      = !do_center;
         phase_in    = done_job ? PH_FIRST : PH_SECOND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      next_row_ff <= next_row_in;
      lof_ff      <= lof_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.next_row      = lgre_pkg::ROW_W'(next_row_ff);
   assign rsp.last_of_frame = lof_ff;

   // Second phase only for a frame-ending job with a held row still at the head
   a_second_phase_job : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SECOND) |-> (job_valid && ctl.held && ctl.last))
      else $error("second phase without a matching job");

   // The first row of a two-row job never closes the frame
   a_second_phase_out : assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SECOND) |-> (out_valid_ff && !lof_ff))
      else $error("bad output ahead of the frame's last row");

   // A job kept at the head moves to its second phase
   a_keep_job : assert property (@(posedge clock) disable iff (reset)
      (fire && !done_job) |=> (phase_ff == PH_SECOND))
      else $error("job kept without phase change");

endmodule

@@ sv/life_generation_row_engine_top.sv @@
// Game of Life (B3/S23) row engine, top level.
// Grid rows arrive top first on req_ch (row_bits, last_row). Each row is
// masked to the width held in the csr_ch register (reset 64 columns) and kept
// in a two-row line buffer. Once the row below a held row arrives, the next
// generation of the held row goes out on rsp_ch. A request marked last_row
// also emits the bottom row, flagged with last_of_frame, and clears the buffer.
// Each result passes the job queue and then the output register; the second
// result of a last row comes from the same queued job after the first.
// Throughput: one request per cycle while the job queue is not full; the 64
// lane cell array in the back end retires one result row per cycle while
// rsp_ch does not stall, so a last_row request that closes a frame of two or
// more rows holds its job at the queue head for a second result row.
// Reset clears the line buffer, the queue and the output register and sets
// the width to 64. When rsp_ch stalls, the output register holds its row, the
// queue fills, and req_ch.ready drops once the queue is full.
// Width writes belong between frames with the block drained.
// Depends on lgre_pkg, lgre_if, lgre_front, lgre_fifo and lgre_back.
module life_generation_row_engine_top #(
   parameter int MAX_COLS    = 64,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   lgre_req_if.sink    req_ch,
   lgre_rsp_if.source  rsp_ch,
   lgre_csr_if.sink    csr_ch
);

   localparam int JOB_W = 4 * MAX_COLS + $bits(lgre_pkg::lgre_job_ctl_type);

   logic             push_valid, push_ready;
   logic [JOB_W-1:0] push_data;
   logic             pop_valid, pop_ready;
   logic [JOB_W-1:0] pop_data;

   // Classify and buffer rows
   lgre_front #(
      .COLS  (MAX_COLS),
      .JOB_W (JOB_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr       (csr_ch),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job_data  (push_data)
   );

   // Job queue
   lgre_fifo #(
      .DATA_W (JOB_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Cell lanes and result register
   lgre_back #(
      .COLS  (MAX_COLS),
      .JOB_W (JOB_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job_data  (pop_data),
      .rsp       (rsp_ch)
   );

endmodule
